// ===== src/k_way_run_merger_defines.svh =====
// Assertion macros used by the checker of the run merger
`ifndef K_WAY_RUN_MERGER_DEFINES_SVH
`define K_WAY_RUN_MERGER_DEFINES_SVH

// Clocked assertion, off while reset is held
`define KWRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define KWRM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kwrm_pkg.sv =====
package kwrm_pkg;

  localparam int COUNT_W      = 10;
  localparam int RUN_W        = 9;
  localparam int KEY_W        = 64;
  localparam int ADDR_W       = 31;
  localparam int CMD_W        = 2;
  localparam int DEF_MAX_RUNS = 512;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EMPTY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFILL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXHAUST = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [RUN_W-1:0]  run_index;
    logic [KEY_W-1:0]  sort_key;
    logic [ADDR_W-1:0] record_address;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  merged_key;
    logic [ADDR_W-1:0] merged_address;
    logic [RUN_W-1:0]  source_run;
    logic              all_done;
  } out_item_t;

  // one stored run head
  typedef struct packed {
    logic              live;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
  } head_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } sel_ctrl_t;

endpackage

// ===== src/kwrm_head_mem.sv =====
module kwrm_head_mem
  import kwrm_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_RUNS,
  parameter int IW    = $clog2(DEF_MAX_RUNS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  head_t         wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output head_t         rdata
);

  head_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/kwrm_select.sv =====
module kwrm_select
  import kwrm_pkg::*;
#(
  parameter int IW = $clog2(DEF_MAX_RUNS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sel_ctrl_t     ctrl,
  input  logic [IW-1:0] cand_idx,
  input  head_t         cand,
  output logic          found,
  output logic [IW-1:0] best_idx,
  output head_t         best
);

  logic          found_r;
  logic [IW-1:0] best_idx_r;
  head_t         best_r;
  logic          take;

  // strict less-than keeps the lowest run on ties
  assign take = ctrl.vld && cand.live && (!found_r || (cand.key < best_r.key));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctrl.clear) begin
      best_r     <= cand;
      best_idx_r <= cand_idx;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

// ===== src/k_way_run_merger.sv =====
// Flow: an item that emits a result passes one write, N head reads through the compare unit,
//   drain and load (N = effective run count); the load waits while a held result is stalled.
// Other items leave the block idle, ready for the next item. The block takes no new item while
//   a result is in the making, a pace set by the linear scan of the head memory through its
//   single read port. Reset: synchronous, active low; a clearing pass then marks every run
//   not live, with in_stall high meanwhile. run_count resets to 1.
module k_way_run_merger
  import kwrm_pkg::*;
#(
  parameter int MAX_RUNS = DEF_MAX_RUNS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = (COUNT_W > $clog2(MAX_RUNS + 1)) ? COUNT_W : $clog2(MAX_RUNS + 1);
  localparam logic [CW-1:0] MAX_CW   = CW'(MAX_RUNS);
  localparam logic [IW-1:0] LAST_RUN = IW'(MAX_RUNS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] run_count_r;
  logic [CW-1:0]      loaded_r, loaded_nxt;
  logic [IW-1:0]      last_r, last_nxt;
  logic [IW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic               rvld_r;
  logic [IW-1:0]      ridx_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;
  logic               out_load;

  logic [CW-1:0]      rc_ext, n_eff, idx_ext, loaded_inc;
  logic               accept, loading;
  logic               act_we, act_live, act_scan;
  logic [IW-1:0]      act_addr;

  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr;
  head_t              mem_wdata, mem_rdata;

  sel_ctrl_t          sel_ctrl;
  logic               sel_found;
  logic [IW-1:0]      sel_idx;
  head_t              sel_best;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    rc_ext = CW'(run_count_r);
    if (rc_ext == '0) begin
      n_eff = CW'(1);
    end else if (rc_ext > MAX_CW) begin
      n_eff = MAX_CW;
    end else begin
      n_eff = rc_ext;
    end
  end

  assign idx_ext    = CW'(in_item.run_index);
  assign loaded_inc = loaded_r + CW'(1);
  assign loading    = (loaded_r < n_eff);

  // decode of the accepted command
  always_comb begin
    act_we     = 1'b0;
    act_live   = 1'b0;
    act_scan   = 1'b0;
    act_addr   = last_r;
    loaded_nxt = loaded_r;
    if (accept) begin
      if (loading) begin
        if ((in_item.command == CMD_LOAD || in_item.command == CMD_EMPTY) &&
            (idx_ext < n_eff)) begin
          act_we     = 1'b1;
          act_live   = (in_item.command == CMD_LOAD);
          act_addr   = idx_ext[IW-1:0];
          loaded_nxt = loaded_inc;
          act_scan   = (loaded_inc == n_eff);
        end
      end else if (in_item.command == CMD_REFILL || in_item.command == CMD_EXHAUST) begin
        act_we   = 1'b1;
        act_live = (in_item.command == CMD_REFILL);
        act_addr = last_r;
        act_scan = 1'b1;
      end
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we         = act_we;
      mem_waddr      = act_addr;
      mem_wdata.live = act_live;
      mem_wdata.key  = in_item.sort_key;
      mem_wdata.addr = in_item.record_address;
    end
  end

  assign mem_re = (state_r == ST_SCAN);

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    last_nxt     = last_r;
    out_load     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == LAST_RUN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (act_scan) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IW'(1);
        if (CW'(scan_cnt_r) == n_eff - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (sel_found) begin
            last_nxt = sel_idx;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      run_count_r <= COUNT_W'(1);
      loaded_r    <= '0;
      last_r      <= '0;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      last_r      <= last_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rvld_r      <= mem_re;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        run_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= scan_cnt_r;
    if (out_load) begin
      if (sel_found) begin
        out_r.merged_key     <= sel_best.key;
        out_r.merged_address <= sel_best.addr;
        out_r.source_run     <= RUN_W'(CW'(sel_idx));
        out_r.all_done       <= 1'b0;
      end else begin
        out_r.merged_key     <= '0;
        out_r.merged_address <= '0;
        out_r.source_run     <= '0;
        out_r.all_done       <= 1'b1;
      end
    end
  end

  assign sel_ctrl.clear = accept && act_scan;
  assign sel_ctrl.vld   = rvld_r;

  kwrm_head_mem #(
    .DEPTH (MAX_RUNS),
    .IW    (IW)
  ) u_head_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_cnt_r),
    .rdata (mem_rdata)
  );

  kwrm_select #(
    .IW (IW)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (sel_ctrl),
    .cand_idx (ridx_r),
    .cand     (mem_rdata),
    .found    (sel_found),
    .best_idx (sel_idx),
    .best     (sel_best)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/kwrm_checker.sv =====
`include "k_way_run_merger_defines.svh"

module kwrm_checker
  import kwrm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `KWRM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid,
               "result dropped while stalled")
  `KWRM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_item),
               "stalled result changed")
  `KWRM_ASSERT(a_done_clean,
               out_valid && out_item.all_done |-> (out_item.merged_key == '0) &&
               (out_item.merged_address == '0) && (out_item.source_run == '0),
               "done transfer carries a record")
  `KWRM_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid && in_stall,
                   "block active right after reset")

endmodule

bind k_way_run_merger kwrm_checker u_kwrm_checker (.*);
